// ===== rtl/smp_pkg.sv =====
// smp_pkg: shared types and constants for the square matrix power block.
// No dependencies.
package smp_pkg;

  localparam int unsigned MAX_ORDER_DEF = 4;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ORDER_W       = 3;

  // input word
  typedef struct packed {
    logic [DATA_W-1:0] element_value;
    logic [DATA_W-1:0] power;
    logic              final_element;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              result_last;
  } out_word_t;

endpackage

// ===== rtl/smp_mac.sv =====
// smp_mac: shared multiply-accumulate unit, one product per cycle while en is high.
// Depends on smp_pkg.
module smp_mac (
  input  logic                      clk,
  input  logic                      clr,
  input  logic                      en,
  input  logic [smp_pkg::DATA_W-1:0] a,
  input  logic [smp_pkg::DATA_W-1:0] b,
  output logic [smp_pkg::DATA_W-1:0] acc
);
  import smp_pkg::*;

  logic [DATA_W-1:0]   acc_r;
  logic [2*DATA_W-1:0] prod;

  assign prod = a * b;

  // clear-on-first accumulate, wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= (clr ? '0 : acc_r) + prod[DATA_W-1:0];
    end
  end

  assign acc = acc_r;
endmodule

// ===== rtl/square_matrix_power.sv =====
// square_matrix_power: matrix power by binary square-and-multiply.
// Load: one word per cycle while in_ready is high. Each N*N product runs on one
// shared 32x32 MAC, then a copy pass; one square per exponent bit up to the
// top set bit and one multiply per set bit (64 products at most), with a pick
// step per bit and one more. Results: N*N words, one per cycle when ready.
// Reset: synchronous active-low rst_n; order returns to 4, counters clear.
module square_matrix_power #(
  parameter int unsigned MAX_ORDER = smp_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  smp_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output smp_pkg::out_word_t          out_data,
  input  logic                        cfg_we,
  input  logic [smp_pkg::ORDER_W-1:0] cfg_wdata
);
  import smp_pkg::*;

  localparam int unsigned CELLS = MAX_ORDER * MAX_ORDER;
  localparam int unsigned IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CW    = $clog2(CELLS + 1);
  localparam int unsigned OW    = $clog2(MAX_ORDER + 1);
  localparam int unsigned KW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  typedef enum logic [2:0] {S_LOAD, S_PICK, S_MUL, S_COPY, S_OUT} state_t;

  state_t            state_r;
  logic [ORDER_W-1:0] order_r;
  logic [OW-1:0]     n_r;
  logic [CW-1:0]     load_r;
  logic [DATA_W-1:0] pow_r;
  logic              sq_r;      // 0: acc*base, 1: base*base
  logic [KW-1:0]     row_r, col_r, k_r;
  logic              wb_r;      // MAC result ready for write-back
  logic [CW-1:0]     idx_r;

  logic [DATA_W-1:0] base_m [CELLS];
  logic [DATA_W-1:0] accm_m [CELLS];
  logic [DATA_W-1:0] scr_m  [CELLS];

  // effective order from register
  logic [OW-1:0] n_eff;
  logic [CW-1:0] cells_eff, cells_r;
  always_comb begin
    if (order_r == '0) n_eff = OW'(1);
    else if (32'(order_r) > MAX_ORDER) n_eff = OW'(MAX_ORDER);
    else n_eff = OW'(order_r);
    cells_eff = CW'(n_eff * n_eff);
  end
  assign cells_r = CW'(n_r * n_r);

  // operand addresses
  logic [IW-1:0] a_idx, b_idx, c_idx;
  assign a_idx = IW'(row_r * n_r + k_r);
  assign b_idx = IW'(k_r * n_r + col_r);
  assign c_idx = IW'(row_r * n_r + col_r);

  logic [DATA_W-1:0] op_a, op_b, mac_acc;
  assign op_a = sq_r ? base_m[a_idx] : accm_m[a_idx];
  assign op_b = base_m[b_idx];

  logic mac_en;
  assign mac_en = (state_r == S_MUL) && !wb_r;

  smp_mac u_mac (
    .clk (clk),
    .clr (k_r == '0),
    .en  (mac_en),
    .a   (op_a),
    .b   (op_b),
    .acc (mac_acc)
  );

  logic last_k, last_c, last_r;
  assign last_k = (32'(k_r) + 1 == 32'(n_r));
  assign last_c = (32'(col_r) + 1 == 32'(n_r));
  assign last_r = (32'(row_r) + 1 == 32'(n_r));

  // memories
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && in_valid && load_r < cells_eff) begin
      base_m[IW'(load_r)] <= in_data.element_value;
    end
    if (state_r == S_LOAD && in_valid && in_data.final_element) begin
      for (int i = 0; i < CELLS; i++) begin
        if (CW'(i) >= load_r + CW'(load_r < cells_eff)) base_m[i] <= '0;
        accm_m[i] <= '0;
      end
      for (int i = 0; i < MAX_ORDER; i++) begin
        if (i < 32'(n_eff)) accm_m[i * 32'(n_eff) + i] <= DATA_W'(1);
      end
    end
    if (state_r == S_MUL && wb_r) scr_m[c_idx] <= mac_acc;
    if (state_r == S_COPY) begin
      if (sq_r) base_m[IW'(idx_r)] <= scr_m[IW'(idx_r)];
      else      accm_m[IW'(idx_r)] <= scr_m[IW'(idx_r)];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      order_r <= ORDER_W'(4);
      n_r     <= OW'(1);
      load_r  <= '0;
      pow_r   <= '0;
      sq_r    <= 1'b0;
      row_r   <= '0;
      col_r   <= '0;
      k_r     <= '0;
      wb_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (cfg_we) order_r <= cfg_wdata;
      unique case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (load_r < cells_eff) load_r <= load_r + CW'(1);
            else load_r <= cells_eff;
            if (in_data.final_element) begin
              n_r     <= n_eff;
              pow_r   <= in_data.power;
              state_r <= S_PICK;
            end
          end
        end
        S_PICK: begin
          row_r <= '0; col_r <= '0; k_r <= '0; wb_r <= 1'b0;
          if (pow_r == '0) begin
            idx_r <= '0; state_r <= S_OUT;
          end else begin
            sq_r <= !pow_r[0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (wb_r) begin
            wb_r <= 1'b0;
            k_r  <= '0;
            if (last_c) begin
              col_r <= '0;
              if (last_r) begin
                idx_r <= '0; state_r <= S_COPY;
              end else row_r <= row_r + KW'(1);
            end else col_r <= col_r + KW'(1);
          end else if (last_k) wb_r <= 1'b1;
          else k_r <= k_r + KW'(1);
        end
        S_COPY: begin
          if (idx_r + CW'(1) == cells_r) begin
            if (sq_r) begin
              pow_r <= pow_r >> 1;
              state_r <= S_PICK;
            end else begin
              sq_r <= 1'b1;
              row_r <= '0; col_r <= '0; k_r <= '0;
              state_r <= S_MUL;
            end
          end else idx_r <= idx_r + CW'(1);
        end
        S_OUT: begin
          if (out_ready) begin
            if (idx_r + CW'(1) == cells_r) begin
              load_r <= '0; state_r <= S_LOAD;
            end else idx_r <= idx_r + CW'(1);
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign out_data.result_value = accm_m[IW'(idx_r)];
  assign out_data.result_last  = (idx_r + CW'(1) == cells_r);

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_load_cap: assert property (@(posedge clk) disable iff (!rst_n)
    load_r <= CW'(CELLS)) else $error("load count past capacity");
  a_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.result_last |=> out_valid)
    else $error("result burst broke early");
`endif
endmodule

// ===== sim/smp_checker.sv =====
// smp_checker: watches the word channels of square_matrix_power, predicts the
// powered matrix for each loaded one and compares every result word in order.
// Depends on smp_pkg.
module smp_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  smp_pkg::in_word_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  smp_pkg::out_word_t          out_data,
  input  logic                        cfg_we,
  input  logic [smp_pkg::ORDER_W-1:0] cfg_wdata,
  output int                          err_count,
  output int                          pending
);
  import smp_pkg::*;

  localparam int CELLS = MAX_ORDER_DEF * MAX_ORDER_DEF;
  typedef logic [DATA_W-1:0] mat_t [CELLS];

  logic [ORDER_W-1:0] order_reg;
  mat_t               loaded_mat;
  int                 loaded_cnt;
  out_word_t          power_words_q [$];

  assign pending = power_words_q.size();

  // n-by-n product, wrapping mod 2^32
  function automatic mat_t mat_mul(mat_t a, mat_t b, int n);
    mat_t             p;
    logic [DATA_W-1:0] acc;
    for (int i = 0; i < CELLS; i++) p[i] = '0;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        acc = '0;
        for (int k = 0; k < n; k++) acc += a[r*n+k] * b[k*n+c];
        p[r*n+c] = acc;
      end
    return p;
  endfunction

  // queue the N*N words of base^pw
  task automatic predict_power(int n, logic [DATA_W-1:0] pw);
    mat_t      base, acc_m;
    out_word_t w;
    base = loaded_mat;
    for (int i = 0; i < CELLS; i++) acc_m[i] = '0;
    for (int i = loaded_cnt; i < n*n; i++) base[i] = '0;  // short matrix pads zeros
    for (int i = 0; i < n; i++) acc_m[i*n+i] = 1;
    while (pw != 0) begin
      if (pw[0]) acc_m = mat_mul(acc_m, base, n);
      base = mat_mul(base, base, n);
      pw >>= 1;
    end
    for (int i = 0; i < n*n; i++) begin
      w.result_value = acc_m[i];
      w.result_last  = (i == n*n - 1);
      power_words_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    int        n;
    out_word_t exp_w;
    if (!rst_n) begin
      order_reg  <= 3'd4;
      loaded_cnt = 0;
      err_count  = 0;
      power_words_q.delete();
    end else begin
      // load words; order sampled per word, clamped to 1..MAX_ORDER
      if (in_valid && in_ready) begin
        n = (order_reg == 0) ? 1 : (order_reg > MAX_ORDER_DEF) ? MAX_ORDER_DEF : order_reg;
        if (loaded_cnt < n*n) begin
          loaded_mat[loaded_cnt] = in_data.element_value;
          loaded_cnt++;
        end else loaded_cnt = n*n;
        if (in_data.final_element) begin
          predict_power(n, in_data.power);
          loaded_cnt = 0;
        end
      end
      // result words
      if (out_valid && out_ready) begin
        if (power_words_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          err_count++;
        end else begin
          exp_w = power_words_q.pop_front();
          if (out_data.result_value !== exp_w.result_value) begin
            $error("result_value exp %h got %h", exp_w.result_value, out_data.result_value);
            err_count++;
          end
          if (out_data.result_last !== exp_w.result_last) begin
            $error("result_last exp %b got %b", exp_w.result_last, out_data.result_last);
            err_count++;
          end
        end
      end
      if (cfg_we) order_reg <= cfg_wdata;
    end
  end

endmodule

// ===== sim/tb_square_matrix_power.sv =====
// tb_square_matrix_power: stimulus and verdict for square_matrix_power.
// Depends on smp_pkg, square_matrix_power and smp_checker.
module tb_square_matrix_power;
  import smp_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_word_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_data;
  logic               cfg_we = 1'b0;
  logic [ORDER_W-1:0] cfg_wdata = '0;
  int                 err_count, pending;
  int                 send_gap_pct, sink_gap_pct, sink_hold;
  int                 words_sent, idle_cycles;

  square_matrix_power dut (.*);

  smp_checker u_chk (.*);

  initial forever #4 clk = ~clk;

  // receiver: random stalls plus an optional long hold-off
  initial begin
    sink_hold = 0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        sink_hold--;
      end else out_ready <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] elem, logic [31:0] pw, logic fin);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{element_value: elem, power: pw, final_element: fin};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_order(logic [ORDER_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one matrix of cnt words, final on the last
  task automatic send_matrix(int cnt, logic [31:0] pw, bit full_range);
    logic [31:0] e;
    for (int i = 0; i < cnt; i++) begin
      e = full_range ? $urandom() : $urandom_range(7);
      send_word(e, pw, i == cnt - 1);
    end
  endtask

  initial begin
    int n, cnt, r;
    logic [31:0] pw;
    words_sent = 0;
    idle_cycles = 0;
    send_gap_pct = 22;
    sink_gap_pct = 49;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset order 4, power zero gives identity
    send_matrix(16, 0, 1);
    write_order(2);
    send_matrix(4, 1, 1);
    send_word(32'hFFFF_FFFF, 0, 0);
    send_word(32'hFFFF_FFFF, 0, 0);
    send_word(32'hFFFF_FFFF, 0, 0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    // short matrix: final after two words
    send_word(5, 0, 0);
    send_word(3, 3, 1);
    // extra words past N*N are dropped
    send_matrix(7, 5, 1);
    write_order(0);                      // order zero runs as 1
    send_word(32'h8000_0001, 32'h7, 1);
    write_order(7);                      // saturates to MAX_ORDER
    send_matrix(3, 2, 0);

    // random phases: 22/49, then 49/22, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 22 : (ph == 1) ? 49 : 0;
      sink_gap_pct = (ph == 0) ? 49 : (ph == 1) ? 22 : 0;
      while (words_sent < 30 + (ph + 1) * 90) begin
        write_order($urandom_range(7));
        for (int m = 0; m < 4; m++) begin
          n  = (cfg_wdata == 0) ? 1 : (cfg_wdata > 4) ? 4 : cfg_wdata;
          r  = $urandom_range(9);
          cnt = (r == 0) ? $urandom_range(1, n*n) : (r == 1) ? n*n + $urandom_range(1, 3) : n*n;
          pw = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(12);
          send_matrix(cnt, pw, $urandom_range(1));
        end
      end
      // long receiver hold-off while words keep coming
      if (ph == 1) begin
        write_order(2);
        sink_hold = 400;
        for (int m = 0; m < 3; m++) send_matrix(4, $urandom_range(1, 5), 1);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (err_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
